[rtl/stbs_pkg.sv]
// Package for the sorted table binary search: field widths, command codes, sequencer states.
package stbs_pkg;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 256;

  localparam int unsigned DATA_W     = 32;  // table entry and target width
  localparam int unsigned IN_IDX_W   = 8;   // entry_index and range_low width
  localparam int unsigned IN_HIGH_W  = 9;   // range_high width (signed)
  localparam int unsigned OUT_IDX_W  = 8;   // found_index width

  // Packed input tdata: entry_index, entry_value, target_value, range_low, range_high.
  localparam int unsigned IN_FIELDS_W = IN_IDX_W + DATA_W + DATA_W + IN_IDX_W + IN_HIGH_W;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_IDX_W + 7) / 8) * 8;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_DONE
  } stbs_state_e;

endpackage

[rtl/sorted_table_binary_search.sv]
// Top level: sorted table binary search with a shared probe/compare sequencer.
// Write beat: accepted while idle, no result beat.
// Search beat: each probe addresses the midpoint (ST_PROBE), then compares the read data
//   (ST_COMPARE); the sequencer enters from ST_IDLE, ends with an empty-range check in
//   ST_PROBE or a hit, and loads the result in ST_DONE once the output register is free.
// tready is high only while the sequencer idles; the result register lets a new beat in
//   while the last result still waits. rst_ni clears control state; the table is not cleared.
module sorted_table_binary_search #(
  parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata, lowest bit up: entry_index[7:0], entry_value[31:0], target_value[31:0],
  //   range_low[7:0], range_high[8:0] (signed), zero padding to 96 bits
  input  logic [stbs_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: command (0 = write entry, 1 = search)
  input  logic                           s_axis_tuser_i,
  // Output stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata, lowest bit up: found_index[7:0]
  output logic [stbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: found
  output logic                           m_axis_tuser_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  // Position width: wide enough for any input index and any table index.
  localparam int unsigned POS_W = (IDX_W > stbs_pkg::IN_IDX_W) ? IDX_W : stbs_pkg::IN_IDX_W;
  // Signed bound width: holds -1 and one past the last index.
  localparam int unsigned BW    = POS_W + 2;
  localparam logic signed [BW-1:0] LAST_IDX = BW'(TABLE_DEPTH - 1);

  // Unpack the input beat.
  logic [stbs_pkg::IN_IDX_W-1:0]         in_entry_index;
  logic signed [stbs_pkg::DATA_W-1:0]    in_entry_value;
  logic signed [stbs_pkg::DATA_W-1:0]    in_target_value;
  logic [stbs_pkg::IN_IDX_W-1:0]         in_range_low;
  logic signed [stbs_pkg::IN_HIGH_W-1:0] in_range_high;

  localparam int unsigned OFS_VALUE  = stbs_pkg::IN_IDX_W;
  localparam int unsigned OFS_TARGET = OFS_VALUE + stbs_pkg::DATA_W;
  localparam int unsigned OFS_LOW    = OFS_TARGET + stbs_pkg::DATA_W;
  localparam int unsigned OFS_HIGH   = OFS_LOW + stbs_pkg::IN_IDX_W;

  assign in_entry_index  = s_axis_tdata_i[stbs_pkg::IN_IDX_W-1:0];
  assign in_entry_value  = s_axis_tdata_i[OFS_VALUE +: stbs_pkg::DATA_W];
  assign in_target_value = s_axis_tdata_i[OFS_TARGET +: stbs_pkg::DATA_W];
  assign in_range_low    = s_axis_tdata_i[OFS_LOW +: stbs_pkg::IN_IDX_W];
  assign in_range_high   = s_axis_tdata_i[OFS_HIGH +: stbs_pkg::IN_HIGH_W];

  stbs_pkg::stbs_state_e state_q, state_d;

  // Search bounds, midpoint and target.
  logic signed [BW-1:0]              lo_q, lo_d;
  logic signed [BW-1:0]              hi_q, hi_d;
  logic signed [BW-1:0]              mid_q, mid_d;
  logic signed [stbs_pkg::DATA_W-1:0] target_q, target_d;

  // Pending result and output register.
  logic                              res_found_q, res_found_d;
  logic [stbs_pkg::OUT_IDX_W-1:0]    res_idx_q, res_idx_d;
  logic                              out_valid_q, out_valid_d;
  logic                              out_found_q, out_found_d;
  logic [stbs_pkg::OUT_IDX_W-1:0]    out_idx_q, out_idx_d;

  logic                              in_fire;
  logic                              wr_en;
  logic [POS_W-1:0]                  wr_pos;
  logic                              wr_in_range;
  logic signed [BW-1:0]              lo_start;
  logic signed [BW-1:0]              hi_ext;
  logic signed [BW-1:0]              hi_start;
  logic signed [BW-1:0]              mid_calc;
  logic [IDX_W-1:0]                  rd_addr;
  logic [stbs_pkg::DATA_W-1:0]       rd_data;
  logic signed [stbs_pkg::DATA_W-1:0] probe_value;

  assign s_axis_tready_o = (state_q == stbs_pkg::ST_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;

  // Writes beyond the table depth are dropped.
  assign wr_pos      = POS_W'(in_entry_index);
  assign wr_in_range = ({1'b0, wr_pos} < (POS_W + 1)'(TABLE_DEPTH));
  assign wr_en       = in_fire & (s_axis_tuser_i == stbs_pkg::CMD_WRITE) & wr_in_range;

  // Starting bounds: saturate the high bound to the last table index.
  assign lo_start = BW'(in_range_low);
  assign hi_ext   = BW'(in_range_high);
  assign hi_start = (hi_ext > LAST_IDX) ? LAST_IDX : hi_ext;

  // Midpoint: low plus half the (non-negative) span, rounded down.
  assign mid_calc = lo_q + ((hi_q - lo_q) >>> 1);
  assign rd_addr  = mid_calc[IDX_W-1:0];

  stbs_ram #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_pos[IDX_W-1:0]),
    .wr_data_i (in_entry_value),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign probe_value = rd_data;

  always_comb begin
    state_d     = state_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    target_d    = target_q;
    res_found_d = res_found_q;
    res_idx_d   = res_idx_q;
    // Drop the result once the sink takes it.
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;

    unique case (state_q)
      stbs_pkg::ST_IDLE: begin
        if (in_fire && (s_axis_tuser_i == stbs_pkg::CMD_SEARCH)) begin
          lo_d     = lo_start;
          hi_d     = hi_start;
          target_d = in_target_value;
          state_d  = stbs_pkg::ST_PROBE;
        end
      end
      stbs_pkg::ST_PROBE: begin
        if (lo_q > hi_q) begin
          // Range empty: report not-found.
          res_found_d = 1'b0;
          res_idx_d   = '0;
          state_d     = stbs_pkg::ST_DONE;
        end else begin
          mid_d   = mid_calc;
          state_d = stbs_pkg::ST_COMPARE;
        end
      end
      stbs_pkg::ST_COMPARE: begin
        if (probe_value > target_q) begin
          hi_d    = mid_q - BW'(1);
          state_d = stbs_pkg::ST_PROBE;
        end else if (probe_value < target_q) begin
          lo_d    = mid_q + BW'(1);
          state_d = stbs_pkg::ST_PROBE;
        end else begin
          res_found_d = 1'b1;
          res_idx_d   = mid_q[stbs_pkg::OUT_IDX_W-1:0];
          state_d     = stbs_pkg::ST_DONE;
        end
      end
      stbs_pkg::ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_idx_d   = res_idx_q;
          state_d     = stbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = stbs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stbs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    target_q    <= target_d;
    res_found_q <= res_found_d;
    res_idx_q   <= res_idx_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = stbs_pkg::OUT_TDATA_W'(out_idx_q);
  assign m_axis_tuser_o  = out_found_q;

endmodule

[rtl/stbs_ram.sv]
// Single-port-write, single-port-read table memory with registered read data.
module stbs_ram #(
  parameter int unsigned DEPTH  = stbs_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [ADDR_W-1:0]           wr_addr_i,
  input  logic [stbs_pkg::DATA_W-1:0] wr_data_i,
  input  logic [ADDR_W-1:0]           rd_addr_i,
  output logic [stbs_pkg::DATA_W-1:0] rd_data_o
);

  logic [stbs_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [stbs_pkg::DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[sim/tb_top.sv]
// Testbench for the sorted table binary search: directed, random and back-pressure tests.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned DEPTH       = stbs_pkg::DEFAULT_TABLE_DEPTH;
  localparam int unsigned DATA_W      = stbs_pkg::DATA_W;
  localparam int unsigned IN_IDX_W    = stbs_pkg::IN_IDX_W;
  localparam int unsigned IN_HIGH_W   = stbs_pkg::IN_HIGH_W;
  localparam int unsigned OUT_IDX_W   = stbs_pkg::OUT_IDX_W;
  localparam int unsigned OFF_VALUE   = IN_IDX_W;
  localparam int unsigned OFF_TARGET  = OFF_VALUE + DATA_W;
  localparam int unsigned OFF_LOW     = OFF_TARGET + DATA_W;
  localparam int unsigned OFF_HIGH    = OFF_LOW + IN_IDX_W;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_PCT    = 22;
  localparam int unsigned DRAIN_WAIT  = 50;
  localparam logic signed [DATA_W-1:0]    VAL_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0]    VAL_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [IN_HIGH_W-1:0] HIGH_EMPTY = '1;  // -1: empty range

  typedef struct packed {
    logic                        cmd;
    logic [IN_IDX_W-1:0]         index;
    logic signed [DATA_W-1:0]    value;
    logic signed [DATA_W-1:0]    target;
    logic [IN_IDX_W-1:0]         low;
    logic signed [IN_HIGH_W-1:0] high;
  } request_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_IDX_W-1:0] index;
  } lookup_t;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                s_axis_tvalid;
  logic                                s_axis_tready;
  logic [stbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata;
  logic                                s_axis_tuser;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready;
  logic [stbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata;
  logic                                m_axis_tuser;

  // Shadow of the block's table, filled as write beats are accepted
  logic signed [DATA_W-1:0] entry_mem [DEPTH];
  bit                       entry_written [DEPTH];
  lookup_t                  lookups_due [$];

  int errors        = 0;
  int beats_sent    = 0;
  int writes_sent   = 0;
  int searches_sent = 0;
  int hits_due      = 0;
  int cycles        = 0;
  bit idle_en       = 1'b1;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  sorted_table_binary_search #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Walk the probe sequence over the shadow table; flag any probe of an unwritten entry
  function automatic lookup_t search_table(input request_t req, output bit safe);
    int      lo;
    int      hi;
    int      mid;
    bit      done;
    lookup_t res;
    res  = '0;
    safe = 1'b1;
    done = 1'b0;
    lo   = int'(req.low);
    hi   = req.high[IN_HIGH_W-1] ? -1 : int'(req.high[IN_HIGH_W-2:0]);
    if (hi > int'(DEPTH) - 1) hi = int'(DEPTH) - 1;
    while (!done && lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (!entry_written[mid]) begin
        safe = 1'b0;
        done = 1'b1;
      end else if ($signed(entry_mem[mid]) > $signed(req.target)) begin
        hi = mid - 1;
      end else if ($signed(entry_mem[mid]) < $signed(req.target)) begin
        lo = mid + 1;
      end else begin
        res.found = 1'b1;
        res.index = mid[OUT_IDX_W-1:0];
        done      = 1'b1;
      end
    end
    return res;
  endfunction

  // All fields random; callers override what the command uses
  function automatic request_t random_request();
    request_t req;
    req.cmd    = stbs_pkg::CMD_WRITE;
    req.index  = IN_IDX_W'($urandom);
    req.value  = $urandom;
    req.target = $urandom;
    req.low    = IN_IDX_W'($urandom);
    req.high   = IN_HIGH_W'($urandom);
    return req;
  endfunction

  // Offer one beat, hold it until taken, then record what it must produce
  task automatic send_beat(input request_t req);
    bit      safe;
    lookup_t res;
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tdata                          = '0;
    s_axis_tdata[0 +: IN_IDX_W]           = req.index;
    s_axis_tdata[OFF_VALUE +: DATA_W]     = req.value;
    s_axis_tdata[OFF_TARGET +: DATA_W]    = req.target;
    s_axis_tdata[OFF_LOW +: IN_IDX_W]     = req.low;
    s_axis_tdata[OFF_HIGH +: IN_HIGH_W]   = req.high;
    s_axis_tuser                          = req.cmd;
    s_axis_tvalid                         = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (req.cmd == stbs_pkg::CMD_WRITE) begin
      entry_mem[req.index]     = req.value;
      entry_written[req.index] = 1'b1;
      writes_sent++;
    end else begin
      res = search_table(req, safe);
      lookups_due = {lookups_due, res};
      searches_sent++;
      if (res.found) hits_due++;
    end
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_entry(input int idx, input logic signed [DATA_W-1:0] val);
    request_t req;
    req       = random_request();
    req.cmd   = stbs_pkg::CMD_WRITE;
    req.index = IN_IDX_W'(idx);
    req.value = val;
    send_beat(req);
  endtask

  // Turn a search that would touch an unwritten entry into an empty-range search
  task automatic send_search(input request_t req);
    bit      safe;
    lookup_t res;
    res = search_table(req, safe);
    if (!safe) req.high = HIGH_EMPTY;
    send_beat(req);
  endtask

  task automatic search_for(input logic signed [DATA_W-1:0] target, input int lo, input int hi);
    request_t req;
    req        = random_request();
    req.cmd    = stbs_pkg::CMD_SEARCH;
    req.target = target;
    req.low    = IN_IDX_W'(lo);
    req.high   = IN_HIGH_W'(hi);
    send_search(req);
  endtask

  // Ascending run of entries, saturating at the largest value
  task automatic write_run(input int first, input int count, input longint base,
                           input int unsigned step_cap);
    longint v;
    v = base;
    for (int i = 0; i < count && first + i < int'(DEPTH); i++) begin
      write_entry(first + i, v[DATA_W-1:0]);
      v += $urandom_range(step_cap, 0);
      if (v > longint'(VAL_MAX)) v = longint'(VAL_MAX);
    end
  endtask

  // Search for an entry that is there, a near miss or a random value
  task automatic probe_search();
    int k;
    logic signed [DATA_W-1:0] target;
    k = $urandom_range(DEPTH - 1);
    case ($urandom_range(9)) inside
      [0:5]:   target = entry_mem[k];
      6:       target = entry_mem[k] + 1;
      7:       target = entry_mem[k] - 1;
      default: target = $urandom;
    endcase
    if ($urandom_range(4) == 0) search_for(target, 0, DEPTH - 1);
    else search_for(target, $urandom_range(k), $urandom_range(DEPTH - 1, k));
  endtask

  task automatic test_directed();
    write_entry(0, VAL_MIN);
    write_entry(1, -70000);
    write_entry(2, -5);
    write_entry(3, -1);
    write_entry(4, 0);
    write_entry(5, 1);
    write_entry(6, 7);
    write_entry(7, 7);
    write_entry(8, 300);
    write_entry(9, 65536);
    write_entry(10, VAL_MAX - 1);
    write_entry(11, VAL_MAX);
    search_for(VAL_MIN, 0, 11);          // lowest entry
    search_for(VAL_MAX, 0, 11);          // highest entry
    search_for(0, 0, 11);
    search_for(2, 0, 11);                // absent, between entries
    search_for(VAL_MIN + 1, 0, 11);      // absent, just above the lowest
    search_for(7, 0, 11);                // duplicated value
    search_for(7, 5, -1);                // range_high negative: empty at once
    search_for(0, 5, -256);
    search_for(0, 5, 3);                 // range_high below range_low
    search_for(0, 4, 4);                 // one-entry range, hit
    search_for(1, 4, 4);                 // one-entry range, miss
    write_entry(3, 99999);               // break the order
    search_for(-1, 0, 11);
  endtask

  task automatic test_table_fill();
    write_run(0, DEPTH, longint'(VAL_MIN), 1 << 25);
  endtask

  // Mostly searches over a mostly sorted table; some sorted rewrites and some noise
  task automatic test_random_traffic(input int n);
    int       stop_at;
    int       pick;
    int       first;
    int unsigned step_cap;
    request_t req;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        first = $urandom_range(DEPTH - 1);
        case ($urandom_range(3))
          0:       step_cap = 1;
          1:       step_cap = 100;
          2:       step_cap = 1 << 20;
          default: step_cap = 1 << 26;
        endcase
        write_run(first, $urandom_range(2, 24),
                  (first > 0) ? longint'(entry_mem[first-1]) : longint'(VAL_MIN), step_cap);
      end else if (pick < 14) begin
        write_entry($urandom_range(DEPTH - 1), $urandom);
      end else if (pick < 24) begin
        req     = random_request();
        req.cmd = stbs_pkg::CMD_SEARCH;
        send_search(req);
      end else begin
        probe_search();
      end
    end
  endtask

  // Stall the result side for a long stretch while searches keep coming
  task automatic test_back_pressure();
    idle_en = 1'b0;
    hold_reqs++;
    repeat (40) probe_search();
    idle_en = 1'b1;
  endtask

  // Result side: random tready, long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = !(idle_en && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin : check_result
    lookup_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lookups_due.size() == 0) begin
        $display("%0t: result beat with nothing pending (found %0b index %0d)",
                 $time, m_axis_tuser, m_axis_tdata[OUT_IDX_W-1:0]);
        errors++;
      end else begin
        want = lookups_due.pop_front();
        if (m_axis_tuser !== want.found) begin
          $display("%0t: found mismatch, expected %0b actual %0b",
                   $time, want.found, m_axis_tuser);
          errors++;
        end
        if (m_axis_tdata[OUT_IDX_W-1:0] !== want.index) begin
          $display("%0t: found_index mismatch, expected %0d actual %0d",
                   $time, want.index, m_axis_tdata[OUT_IDX_W-1:0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results pending",
               $time, cycles, lookups_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = stbs_pkg::CMD_WRITE;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_table_fill();
    test_random_traffic(350);
    idle_en = 1'b0;
    test_random_traffic(120);
    idle_en = 1'b1;
    test_back_pressure();

    s_axis_tvalid = 1'b0;
    wait (lookups_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run covered %0d beats: %0d table writes, %0d searches (%0d hits expected)",
             beats_sent, writes_sent, searches_sent, hits_due);
    $display("incl. extremes, empty ranges, an unsorted table and a long result-side stall");
    if (errors == 0 && lookups_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/stbs_pkg.sv
rtl/stbs_ram.sv
rtl/sorted_table_binary_search.sv
sim/tb_top.sv
